### hw/rtl/motor_identification_sequencer_top_macros.svh
// Assertion macros shared by the motor identification sequencer.
`ifndef MOTOR_IDENTIFICATION_SEQUENCER_TOP_MACROS_SVH
`define MOTOR_IDENTIFICATION_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MIS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define MIS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

### hw/rtl/mis_pkg.sv
// Types and constants of the motor identification sequencer.
`default_nettype none
package mis_pkg;

   localparam int CountWidth = 16;
   localparam int DutyWidth  = 12;
   localparam int StepWidth  = 10;
   localparam int LimitWidth = 11;
   localparam int LevelWidth = 12;
   localparam int PhaseWidth = 3;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;

   localparam logic [CountWidth-1:0] CountMax = '1;
   localparam logic [DutyWidth-1:0]  DutyMax  = '1;

   localparam logic [CountWidth-1:0] StartupTicksReset    = 16'd500;
   localparam logic [CountWidth-1:0] PeriodTicksReset     = 16'd300;
   localparam logic [StepWidth-1:0]  DutyStepReset        = 10'd100;
   localparam logic [LimitWidth-1:0] DutyLimitReset       = 11'd820;
   localparam logic [LevelWidth-1:0] SaturationLevelReset = 12'd3500;

   typedef enum logic [PhaseWidth-1:0] {
      PH_POWERUP = 3'd0,
      PH_INIT    = 3'd1,
      PH_RESET   = 3'd2,
      PH_MSTART  = 3'd3,
      PH_MINC    = 3'd4,
      PH_MMEAS   = 3'd5,
      PH_MSTOP   = 3'd6
   } phase_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_STARTUP_TICKS    = 3'd0,
      CSR_PERIOD_TICKS     = 3'd1,
      CSR_DUTY_STEP        = 3'd2,
      CSR_DUTY_LIMIT       = 3'd3,
      CSR_SATURATION_LEVEL = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CountWidth-1:0] startup_ticks;
      logic [CountWidth-1:0] period_ticks;
      logic [StepWidth-1:0]  duty_step;
      logic [LimitWidth-1:0] duty_limit;
      logic [LevelWidth-1:0] saturation_level;
   } cfg_type;

   // Packed so that phase lands in the lowest bits of the result word.
   typedef struct packed {
      logic                 measuring;
      logic                 bridge_multi_mode;
      logic                 driver_sleep_pulse;
      logic                 identifier_clear;
      logic                 identifier_wait;
      logic                 adc_start;
      logic                 duty_written;
      logic [DutyWidth-1:0] duty;
      phase_type            phase;
   } result_type;

   localparam int ResultWidth = $bits(result_type);

endpackage
`default_nettype wire

### hw/rtl/mis_csr.sv
// Configuration register file of the motor identification sequencer.
`default_nettype none
module mis_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [mis_pkg::CsrIndexWidth-1:0]     csr_index,
   input  wire logic [mis_pkg::CsrDataWidth-1:0]      csr_wdata,
   output mis_pkg::cfg_type                           cfg
);
   import mis_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_STARTUP_TICKS:    cfg_in.startup_ticks    = csr_wdata;
            CSR_PERIOD_TICKS:     cfg_in.period_ticks     = csr_wdata;
            CSR_DUTY_STEP:        cfg_in.duty_step        = csr_wdata[StepWidth-1:0];
            CSR_DUTY_LIMIT:       cfg_in.duty_limit       = csr_wdata[LimitWidth-1:0];
            CSR_SATURATION_LEVEL: cfg_in.saturation_level = csr_wdata[LevelWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.startup_ticks    <= StartupTicksReset;
         cfg_ff.period_ticks     <= PeriodTicksReset;
         cfg_ff.duty_step        <= DutyStepReset;
         cfg_ff.duty_limit       <= DutyLimitReset;
         cfg_ff.saturation_level <= SaturationLevelReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/mis_step.sv
// Phase machine, tick counter and duty register of the sequencer.
`default_nettype none
module mis_step (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             advance,
   input  wire logic                             cmd,
   input  wire logic [mis_pkg::LevelWidth-1:0]   peak_level,
   input  wire mis_pkg::cfg_type                 cfg,
   output mis_pkg::result_type                   result
);
   import mis_pkg::*;

   phase_type             phase_ff;
   phase_type             phase_in;
   logic [CountWidth-1:0] tick_ff;
   logic [CountWidth-1:0] tick_in;
   logic [DutyWidth-1:0]  duty_ff;
   logic [DutyWidth-1:0]  duty_in;

   phase_type             nxt;
   logic [CountWidth-1:0] tick_sat;
   logic [DutyWidth:0]    duty_sum;
   logic [DutyWidth-1:0]  duty_inc;
   logic                  startup_done;
   logic                  period_done;

   assign tick_sat     = (tick_ff == CountMax) ? tick_ff : tick_ff + 1'b1;
   assign duty_sum     = {1'b0, duty_ff} + {{(DutyWidth + 1 - StepWidth){1'b0}}, cfg.duty_step};
   assign duty_inc     = duty_sum[DutyWidth] ? DutyMax : duty_sum[DutyWidth-1:0];
   assign startup_done = (tick_sat >= cfg.startup_ticks);
   assign period_done  = (tick_sat >= cfg.period_ticks);

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      duty_in  = duty_ff;
      nxt      = phase_ff;
      result   = '0;
      if (cmd) begin
         phase_in         = PH_INIT;
         result.adc_start = 1'b1;
      end else begin
         tick_in = tick_sat;
         unique case (phase_ff)
            PH_POWERUP: begin
               if (startup_done) nxt = PH_RESET;
            end
            PH_INIT: begin
               if (startup_done) begin
                  nxt                    = PH_MSTART;
                  result.identifier_wait = 1'b1;
               end
            end
            PH_MSTART: begin
               if (period_done) nxt = PH_MINC;
            end
            PH_MINC: begin
               nxt = ({{(DutyWidth - LimitWidth){1'b0}}, cfg.duty_limit} < duty_ff)
                     ? PH_MSTOP : PH_MMEAS;
            end
            PH_MMEAS: begin
               // A period expiry in the same tick overrides saturation.
               if (period_done) begin
                  nxt = PH_MINC;
               end else if (peak_level > cfg.saturation_level) begin
                  nxt = PH_MSTOP;
               end
            end
            default: ;
         endcase
         if (nxt != phase_ff) begin
            tick_in  = '0;
            phase_in = nxt;
            unique case (nxt)
               PH_INIT: begin
                  result.adc_start = 1'b1;
               end
               PH_MSTART: begin
                  duty_in                  = '0;
                  result.duty_written      = 1'b1;
                  result.bridge_multi_mode = 1'b1;
               end
               PH_MINC: begin
                  duty_in             = duty_inc;
                  result.duty_written = 1'b1;
               end
               PH_MSTOP: begin
                  duty_in                 = '0;
                  result.identifier_clear = 1'b1;
                  result.duty_written     = 1'b1;
               end
               PH_RESET: begin
                  result.driver_sleep_pulse = 1'b1;
               end
               default: ;
            endcase
         end
      end
      result.phase     = phase_in;
      result.duty      = duty_in;
      result.measuring = (phase_in == PH_MSTART) || (phase_in == PH_MINC) ||
                         (phase_in == PH_MMEAS) || (phase_in == PH_MSTOP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_POWERUP;
         tick_ff  <= '0;
         duty_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         duty_ff  <= duty_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/motor_identification_sequencer_top.sv
// Top level of the motor identification sequencer with its stream channels.
//
// Usage: each req transfer carries one event. req_tuser is the kind: 0 for one
// system tick, 1 for the end of the driver sleep pulse. req_tdata carries the
// smoothed peak current level. Every req transfer yields exactly one rsp
// transfer with the phase, the PWM duty and single-shot action strobes.
// The csr channel writes the five limits by index; it is always ready. Writes
// must be made only while no event is in flight; the block does not enforce it.
// A req transfer is held in the input register, and its result then in the
// result register. Throughput is one event per cycle while the receiver does
// not stall; the phase update is a single registered step, so events may
// follow back to back.
// When the receiver stalls the result register holds its item and the input
// register still takes one more event; req_tready falls once both are full.
// Reset empties both registers, returns the phase machine to power-up with a
// zero tick count and zero duty, and loads the default limits.
`default_nettype none
`include "motor_identification_sequencer_top_macros.svh"
module motor_identification_sequencer_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [15:0]                         req_tdata,  // peak_level [11:0]
   input  wire logic                                req_tuser,  // cmd
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // phase [2:0], duty [14:3], duty_written, adc_start, identifier_wait,
   // identifier_clear, driver_sleep_pulse, bridge_multi_mode, measuring [21]
   output logic [23:0]                              rsp_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [mis_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [mis_pkg::CsrDataWidth-1:0]    csr_wdata
);
   import mis_pkg::*;

   cfg_type               cfg;
   result_type            step_result;
   logic                  advance;

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic                  in_cmd_ff;
   logic [LevelWidth-1:0] in_peak_ff;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   result_type            out_result_ff;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(24 - ResultWidth){1'b0}}, out_result_ff};

   mis_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mis_step u_step (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .cmd        (in_cmd_ff),
      .peak_level (in_peak_ff),
      .cfg        (cfg),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff  <= req_tuser;
         in_peak_ff <= req_tdata[LevelWidth-1:0];
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   `MIS_ASSERT_NEXT(a_held_item_kept, clock, reset, in_valid_ff && !advance, in_valid_ff)
   `MIS_ASSERT_IMPLY(a_adc_only_in_init, clock, reset,
      out_valid_ff && out_result_ff.adc_start, out_result_ff.phase == PH_INIT)
   `MIS_ASSERT_IMPLY(a_duty_write_phase, clock, reset,
      out_valid_ff && out_result_ff.duty_written,
      (out_result_ff.phase == PH_MSTART) || (out_result_ff.phase == PH_MINC) ||
      (out_result_ff.phase == PH_MSTOP))
   `MIS_ASSERT_IMPLY(a_zero_duty_at_stop, clock, reset,
      out_valid_ff && out_result_ff.identifier_clear, out_result_ff.duty == '0)

endmodule
`default_nettype wire
